>>> sv/dda_line_stepper_dashed_macros.svh
// Assertion helpers shared by the line stepper modules.
// Each expects the enclosing module to have clk and rst.
`ifndef DDA_LINE_STEPPER_DASHED_MACROS_SVH
`define DDA_LINE_STEPPER_DASHED_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dls: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dls: next-cycle check failed");

`endif

>>> sv/dls_pkg.sv
package dls_pkg;

  // Request kinds carried on the input tuser bit.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int  DASH_W     = 8;
  localparam logic [DASH_W-1:0] DASH_RESET = 8'd1;

  // Status of the increment divider as seen by the back end.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> sv/dda_line_stepper_dashed.sv
// DDA line stepper with dashed output.
// Input channel (s_*): tuser selects the request kind. A start request
// (tuser 0) carries both endpoints in tdata and produces no output; a tick
// request (tuser 1) produces the next point of the current line. Ticks with
// no active line are dropped. A start during a line abandons that line.
// Output channel (m_*): tdata holds the rounded point, tuser is the plot
// flag for dashing and tlast marks the final point of the line.
// Configuration: cfg_wr_en writes cfg_wr_data into the dash spacing
// register (reset value 1, solid line); zero behaves like one.
// With the back end free, an accepted tick passes through the queue and
// the output register to m_tvalid, and ticks stream at one per cycle
// while the receiver is ready. A start holds the back end while the
// bit-serial divider forms both increments; requests behind it wait in the
// two-entry queue.
// Reset clears the queue, ends any active line and restores the spacing.
// When the receiver stalls, the output register holds its point and the
// queue absorbs up to two more requests before s_tready falls.
module dda_line_stepper_dashed #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [7:0]                           cfg_wr_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata from bit 0: x_start, y_start, x_end, y_end, zero fill.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // s_tuser: opcode (0 start, 1 tick).
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata from bit 0: point_x, point_y, zero fill.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  // m_tuser: plot.
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  // Queue entry: x_start, y_start, |dx|, |dy|, step, two signs, kind.
  localparam int QW = 5 * COORD_BITS + 3;

  logic          q_full, q_empty, q_push, q_pop;
  logic [QW-1:0] q_in, q_out;

  // The front end classifies each request and precomputes the deltas.
  dls_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // The queue lets the front keep accepting while the back end divides.
  dls_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // The back end holds the line state, runs the divider and drives output.
  dls_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (q_out),
    .empty       (q_empty),
    .pop         (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

>>> sv/dls_front.sv
module dls_front #(
  parameter int COORD_BITS = 11
) (
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  input  logic                                   s_tuser,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [5*COORD_BITS+2:0]                q_entry
);

  localparam int C = COORD_BITS;

  logic [C-1:0] xs, ys, xe, ye;
  logic [C-1:0] adx, ady, step;
  logic         neg_x, neg_y, is_tick;

  // Deltas and the step count are worked out here so that the back end
  // only has to divide.
  always_comb begin
    xs      = s_tdata[C-1:0];
    ys      = s_tdata[2*C-1:C];
    xe      = s_tdata[3*C-1:2*C];
    ye      = s_tdata[4*C-1:3*C];
    neg_x   = (xe < xs);
    neg_y   = (ye < ys);
    adx     = neg_x ? (xs - xe) : (xe - xs);
    ady     = neg_y ? (ys - ye) : (ye - ys);
    step    = (adx > ady) ? adx : ady;
    is_tick = (s_tuser == dls_pkg::OP_TICK);
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_entry  = {is_tick, neg_y, neg_x, step, ady, adx, ys, xs};

endmodule

>>> sv/dls_queue.sv
module dls_queue #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wr_ptr, rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]) && (wr_ptr[AW] != rd_ptr[AW]);
  assign dout  = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[AW-1:0]] <= din;
    end
  end

endmodule

>>> sv/dls_div.sv
`include "dda_line_stepper_dashed_macros.svh"

module dls_div #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [COORD_BITS-1:0]     divisor,
  input  logic [COORD_BITS-1:0]     num_a,
  input  logic [COORD_BITS-1:0]     num_b,
  output logic [FRAC_BITS:0]        quo_a,
  output logic [FRAC_BITS:0]        quo_b,
  output dls_pkg::div_status_t      st
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int CNT_W = $clog2(F + 2);

  logic [C:0]       rem_a, rem_b;
  logic [C-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic             ge_a, ge_b;
  logic [C:0]       diff_a, diff_b;
  logic [C-1:0]     sub_a, sub_b;

  // Restoring division, one quotient bit per cycle for both axes. The
  // numerator never exceeds the divisor, so F+1 bits cover the quotient.
  always_comb begin
    ge_a   = (rem_a >= {1'b0, dvs});
    ge_b   = (rem_b >= {1'b0, dvs});
    diff_a = rem_a - {1'b0, dvs};
    diff_b = rem_b - {1'b0, dvs};
    sub_a  = ge_a ? diff_a[C-1:0] : rem_a[C-1:0];
    sub_b  = ge_b ? diff_b[C-1:0] : rem_b[C-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(F + 1);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_a <= {1'b0, num_a};
      rem_b <= {1'b0, num_b};
      dvs   <= divisor;
    end else if (cnt != '0) begin
      rem_a <= {sub_a, 1'b0};
      rem_b <= {sub_b, 1'b0};
      quo_a <= {quo_a[F-1:0], ge_a};
      quo_b <= {quo_b[F-1:0], ge_b};
    end
  end

  assign st.busy = (cnt != '0);
  assign st.done = done;

  `DLS_ASSERT_SAME(a_start_idle, start, !st.busy)
  `DLS_ASSERT_NEXT(a_done_pulse, st.done, !st.done && !st.busy)
  `DLS_ASSERT_SAME(a_done_not_busy, st.done, !st.busy)

endmodule

>>> sv/dls_back.sv
`include "dda_line_stepper_dashed_macros.svh"

module dls_back #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [dls_pkg::DASH_W-1:0]           cfg_wr_data,
  input  logic [5*COORD_BITS+2:0]              head,
  input  logic                                 empty,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int PW    = C + F + 1;
  localparam int IW    = F + 2;
  localparam int SW    = C + 1;
  localparam int OUT_W = ((2*C+7)/8)*8;
  localparam int DW    = dls_pkg::DASH_W;

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic [C-1:0] h_xs, h_ys, h_adx, h_ady, h_step;
  logic         h_neg_x, h_neg_y, h_tick;

  assign {h_tick, h_neg_y, h_neg_x, h_step, h_ady, h_adx, h_ys, h_xs} = head;

  logic          state;
  logic          active;
  logic [PW-1:0] pos_x, pos_y;
  logic [IW-1:0] inc_x, inc_y;
  logic [SW-1:0] steps_left;
  logic [DW-1:0] dash_phase, dash_spacing;
  logic          neg_x, neg_y, step_zero;
  logic          out_valid, out_plot, out_last;
  logic [C-1:0]  out_x, out_y;

  logic          out_free, load_start, load_tick, is_last, div_finish;
  logic [F:0]    quo_x, quo_y;
  logic [IW-1:0] mag_x, mag_y;
  logic [PW-1:0] rnd_x, rnd_y;
  logic [DW-1:0] spacing_eff, phase_next;
  logic [DW:0]   phase_inc;
  dls_pkg::div_status_t div_st;

  dls_div #(
    .COORD_BITS (C),
    .FRAC_BITS  (F)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (load_start),
    .divisor (h_step),
    .num_a   (h_adx),
    .num_b   (h_ady),
    .quo_a   (quo_x),
    .quo_b   (quo_y),
    .st      (div_st)
  );

  always_comb begin
    out_free    = !out_valid || m_tready;
    pop         = (state == ST_RUN) && !empty && (h_tick ? out_free : 1'b1);
    load_start  = pop && !h_tick;
    load_tick   = pop && h_tick && active;
    div_finish  = (state == ST_DIV) && div_st.done;
    is_last     = (steps_left <= SW'(1));
    mag_x       = {1'b0, quo_x};
    mag_y       = {1'b0, quo_y};
    rnd_x       = pos_x + (PW'(1) << (F - 1));
    rnd_y       = pos_y + (PW'(1) << (F - 1));
    spacing_eff = (dash_spacing == '0) ? DW'(1) : dash_spacing;
    phase_inc   = {1'b0, dash_phase} + 1'b1;
    phase_next  = (phase_inc >= {1'b0, spacing_eff}) ? '0 : phase_inc[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      active       <= 1'b0;
      steps_left   <= '0;
      dash_phase   <= '0;
      dash_spacing <= dls_pkg::DASH_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dash_spacing <= cfg_wr_data;
      end
      priority if (load_start) begin
        state      <= ST_DIV;
        active     <= 1'b1;
        steps_left <= {1'b0, h_step} + 1'b1;
        dash_phase <= '0;
      end else if (div_finish) begin
        state <= ST_RUN;
      end else if (load_tick) begin
        dash_phase <= phase_next;
        if (is_last) begin
          active     <= 1'b0;
          steps_left <= '0;
        end else begin
          steps_left <= steps_left - 1'b1;
        end
      end
      if (load_tick) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_start) begin
      pos_x     <= {1'b0, h_xs, {F{1'b0}}};
      pos_y     <= {1'b0, h_ys, {F{1'b0}}};
      neg_x     <= h_neg_x;
      neg_y     <= h_neg_y;
      step_zero <= (h_step == '0);
    end else if (load_tick) begin
      pos_x <= pos_x + {{(PW-IW){inc_x[IW-1]}}, inc_x};
      pos_y <= pos_y + {{(PW-IW){inc_y[IW-1]}}, inc_y};
    end
    if (div_finish) begin
      inc_x <= step_zero ? '0 : (neg_x ? -mag_x : mag_x);
      inc_y <= step_zero ? '0 : (neg_y ? -mag_y : mag_y);
    end
    if (load_tick) begin
      out_x    <= rnd_x[F+C-1:F];
      out_y    <= rnd_y[F+C-1:F];
      out_plot <= (dash_phase == '0);
      out_last <= is_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_y, out_x});
  assign m_tuser  = out_plot;
  assign m_tlast  = out_last;

  `DLS_ASSERT_SAME(a_no_pop_in_div, state == ST_DIV, !pop)
  `DLS_ASSERT_SAME(a_finish_in_div, div_st.done, state == ST_DIV)
  `DLS_ASSERT_NEXT(a_last_ends_line, load_tick && is_last, !active)

endmodule

>>> tb/tb_dda_line_stepper_dashed.sv
`timescale 1ns / 100ps

// Self-checking bench for the dashed DDA line stepper.
//
// Start requests load two endpoints, and tick requests walk the line one point
// at a time. A behavioral line model in this file follows every accepted
// request and queues the point that each tick should produce. A monitor
// compares every point that leaves the block against the oldest queued point,
// field by field.
//
// The tests run in this order:
//   - short directed lines: extreme coordinates, a tick with no line, a
//     zero-length line, a start that cuts a running line short, and the
//     half-pixel rounding cases;
//   - dash spacing: several spacings, a spacing change in the middle of a line
//     that forces the phase counter to wrap, spacing zero, and the widest
//     spacing;
//   - backpressure: the receiver holds off for a long stretch while the sender
//     keeps pushing, so the request queue fills and s_tready drops;
//   - random lines: mostly complete lines with random endpoints, some cut
//     short, some followed by stray ticks, and some pure noise, spread over
//     several spacings and idling patterns.
module tb_dda_line_stepper_dashed;

  localparam int COORD_W = 11;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = COORD_W + FRAC_W + 1;
  localparam int INC_W   = FRAC_W + 2;
  localparam int S_W     = ((4*COORD_W+7)/8)*8;
  localparam int M_W     = ((2*COORD_W+7)/8)*8;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam logic [POS_W:0] HALF_PIXEL = (POS_W+1)'(1) << (FRAC_W - 1);

  // Two back-to-back starts can each hold the back end for the divider, so
  // this is how long the block may stay busy with no point left to deliver.
  localparam int SETTLE_CYCLES = 2 * (FRAC_W + 3) + 10;
  localparam int TARGET_REQUESTS = 1300;
  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               plot;
    logic               last;
  } point_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_pattern_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [S_W-1:0]     s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [M_W-1:0]     m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  // Line model state, mirrored from the block's point of view.
  logic [dls_pkg::DASH_W-1:0] dash_spacing_q;
  logic               line_active;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [INC_W-1:0]   inc_x;
  logic [INC_W-1:0]   inc_y;
  logic [COORD_W:0]   points_left;
  logic [dls_pkg::DASH_W-1:0] dash_phase;
  point_t             pending_points[$];

  // Stimulus controls shared between the tests and the two drivers.
  rx_pattern_t rx_pattern = RX_ALWAYS;
  int          hold_off_left = 0;
  bit          tx_gaps = 1'b0;
  int          burst_left = 0;

  // Counters for the final report.
  int mismatches = 0;
  int counted_requests = 0;
  int lines_started = 0;
  int points_checked = 0;
  int points_plotted = 0;
  int lines_finished = 0;
  int spacing_writes = 0;
  int input_stall_cycles = 0;

  dda_line_stepper_dashed u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed Q16 step for one axis: the magnitude is truncated toward zero, and
  // then the sign of the delta is applied in two's complement.
  function automatic logic [INC_W-1:0] dda_increment(input logic [COORD_W-1:0] from,
                                                     input logic [COORD_W-1:0] to,
                                                     input logic [COORD_W-1:0] span);
    logic [31:0]      delta;
    logic [31:0]      mag;
    logic [INC_W-1:0] mag_q;
    if (span == '0) begin
      return '0;
    end
    delta = (to >= from) ? 32'(to - from) : 32'(from - to);
    mag = (delta << FRAC_W) / 32'(span);
    mag_q = mag[INC_W-1:0];
    return (to >= from) ? mag_q : (~mag_q + 1'b1);
  endfunction

  // Apply one accepted request to the line model. A tick on an active line
  // queues the point that the block has to produce for it.
  task automatic rasterize_request(input logic op, input logic [S_W-1:0] data);
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic [COORD_W-1:0] span;
    logic [POS_W:0]     rounded_x;
    logic [POS_W:0]     rounded_y;
    logic [dls_pkg::DASH_W:0]   next_phase;
    logic [dls_pkg::DASH_W-1:0] spacing;
    point_t             pt;
    xs = data[0*COORD_W +: COORD_W];
    ys = data[1*COORD_W +: COORD_W];
    xe = data[2*COORD_W +: COORD_W];
    ye = data[3*COORD_W +: COORD_W];
    if (op == dls_pkg::OP_START) begin
      adx = (xs >= xe) ? xs - xe : xe - xs;
      ady = (ys >= ye) ? ys - ye : ye - ys;
      span = (adx > ady) ? adx : ady;
      inc_x = dda_increment(xs, xe, span);
      inc_y = dda_increment(ys, ye, span);
      pos_x = POS_W'({xs, {FRAC_W{1'b0}}});
      pos_y = POS_W'({ys, {FRAC_W{1'b0}}});
      points_left = {1'b0, span} + 1'b1;
      dash_phase = '0;
      line_active = 1'b1;
      lines_started++;
      counted_requests++;
    end else if (line_active) begin
      // A spacing of zero behaves like a solid line.
      spacing = (dash_spacing_q == '0) ? dls_pkg::DASH_W'(1) : dash_spacing_q;
      rounded_x = {1'b0, pos_x} + HALF_PIXEL;
      rounded_y = {1'b0, pos_y} + HALF_PIXEL;
      pt.x = rounded_x[FRAC_W +: COORD_W];
      pt.y = rounded_y[FRAC_W +: COORD_W];
      pt.plot = (dash_phase == '0);
      pt.last = (points_left <= 1);
      pending_points.push_back(pt);
      pos_x = pos_x + {{(POS_W-INC_W){inc_x[INC_W-1]}}, inc_x};
      pos_y = pos_y + {{(POS_W-INC_W){inc_y[INC_W-1]}}, inc_y};
      // The phase wraps once it reaches or passes the spacing, which also
      // covers a spacing that shrank in the middle of a line.
      next_phase = {1'b0, dash_phase} + 1'b1;
      dash_phase = (next_phase >= {1'b0, spacing}) ? '0
                                                   : next_phase[dls_pkg::DASH_W-1:0];
      if (pt.last) begin
        points_left = '0;
        line_active = 1'b0;
      end else begin
        points_left = points_left - 1'b1;
      end
      counted_requests++;
    end
  endtask

  // Printing stops after the first few mismatches so that a badly broken
  // block cannot flood the log. Every mismatch is still counted.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d (point %0d)",
               $time, what, got, want, points_checked);
    end
  endtask

  // The monitor samples both handshakes at the rising edge. It updates the line
  // model before it checks the output, so a same-cycle point would still find
  // its expectation.
  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (rst) begin
      dash_spacing_q = dls_pkg::DASH_RESET;
      line_active = 1'b0;
      pos_x = '0;
      pos_y = '0;
      inc_x = '0;
      inc_y = '0;
      points_left = '0;
      dash_phase = '0;
      pending_points.delete();
    end else begin
      if (cfg_wr_en) begin
        dash_spacing_q = cfg_wr_data;
        spacing_writes++;
      end
      if (s_tvalid && !s_tready) begin
        input_stall_cycles++;
      end
      if (s_tvalid && s_tready) begin
        rasterize_request(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[0 +: COORD_W];
        got.y = m_tdata[COORD_W +: COORD_W];
        got.plot = m_tuser;
        got.last = m_tlast;
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected point, x", int'(got.x), -1);
        end else begin
          want = pending_points.pop_front();
          if (got.x !== want.x) report_mismatch("point_x", int'(got.x), int'(want.x));
          if (got.y !== want.y) report_mismatch("point_y", int'(got.y), int'(want.y));
          if (got.plot !== want.plot) begin
            report_mismatch("plot", int'(got.plot), int'(want.plot));
          end
          if (got.last !== want.last) begin
            report_mismatch("last", int'(got.last), int'(want.last));
          end
          if (want.plot) points_plotted++;
          if (want.last) lines_finished++;
        end
        points_checked++;
      end
    end
  end

  // The receiver changes m_tready at falling edges only. A long hold-off that
  // a test asks for takes priority over the current stall pattern.
  initial begin : receiver
    int pattern_pos;
    int stall_left;
    pattern_pos = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_pattern)
          RX_ALWAYS: begin
            m_tready <= 1'b1;
          end
          RX_RANDOM: begin
            m_tready <= ($urandom_range(0, 2) != 0);
          end
          RX_PERIODIC: begin
            pattern_pos = (pattern_pos + 1) % 5;
            m_tready <= (pattern_pos < 3);
          end
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_tready <= 1'b0;
            end else begin
              if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(2, 8);
              end
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one request and return at the edge that accepts it. When gaps are
  // enabled, the sender works in bursts of random length with idle stretches
  // between them. s_tvalid stays high from one request to the next whenever
  // no gap falls between them.
  task automatic send_request(input logic op, input logic [COORD_W-1:0] xs,
                              input logic [COORD_W-1:0] ys, input logic [COORD_W-1:0] xe,
                              input logic [COORD_W-1:0] ye);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= S_W'({ye, xe, ys, xs});
    do @(posedge clk); while (!s_tready);
  endtask

  // A tick carries random data in tdata, which the block must ignore.
  task automatic send_tick();
    send_request(dls_pkg::OP_TICK,
                 COORD_W'($urandom_range(0, COORD_MAX)),
                 COORD_W'($urandom_range(0, COORD_MAX)),
                 COORD_W'($urandom_range(0, COORD_MAX)),
                 COORD_W'($urandom_range(0, COORD_MAX)));
  endtask

  task automatic run_line(input int xs, input int ys, input int xe, input int ye,
                          input int ticks);
    send_request(dls_pkg::OP_START, COORD_W'(xs), COORD_W'(ys), COORD_W'(xe),
                 COORD_W'(ye));
    repeat (ticks) send_tick();
  endtask

  // Wait until every queued point has arrived. Then give the block time to
  // finish any start that is still in the divider.
  task automatic drain_block();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The spacing register is written only while the block is idle.
  task automatic write_spacing(input int value);
    drain_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 8'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed_lines();
    rx_pattern = RX_ALWAYS;
    tx_gaps = 1'b0;
    // A tick right after reset finds no line and must produce nothing.
    send_tick();
    // Zero-length line: exactly one point, plotted and last. The tick after
    // it is ignored.
    run_line(COORD_MAX, 0, COORD_MAX, 0, 2);
    // Full-diagonal line across the extremes, cut short by a new start that
    // runs backwards in both axes.
    run_line(0, 0, COORD_MAX, COORD_MAX, 3);
    run_line(COORD_MAX, COORD_MAX, COORD_MAX - 4, COORD_MAX - 2, 5);
    // Increments of two thirds of a pixel in y fall on both sides of half-pixel rounding.
    run_line(10, 10, 13, 12, 4);
    // A vertical line that runs upward, with x held constant.
    run_line(100, 100, 100, 95, 6);
    drain_block();
  endtask

  task automatic test_dash_spacing();
    rx_pattern = RX_RANDOM;
    tx_gaps = 1'b1;
    write_spacing(3);
    run_line(0, 0, 20, 7, 21);
    // Stop with the phase at four, then shrink the spacing to two, so the
    // phase counter has to wrap on a value past the new spacing.
    write_spacing(5);
    run_line(50, 60, 30, 90, 4);
    write_spacing(2);
    repeat (27) send_tick();
    // A spacing of zero must give a solid line.
    write_spacing(0);
    run_line(7, 3, 1, 0, 7);
    // The widest spacing: only the first point and point 255 are plotted.
    write_spacing(255);
    run_line(1800, 40, COORD_MAX, 300, 261);
    drain_block();
  endtask

  task automatic test_backpressure();
    write_spacing(1);
    tx_gaps = 1'b0;
    rx_pattern = RX_ALWAYS;
    // The receiver stays stalled while a whole line is offered. The queue fills,
    // and the sender then waits on s_tready.
    hold_off_left = 300;
    run_line(400, 900, 480, 870, 81);
    drain_block();
  endtask

  // One random sequence: mostly whole lines with random endpoints. Some lines
  // are cut short, some are followed by stray ticks, and a few requests are
  // plain noise.
  task automatic random_sequence();
    int kind;
    int xs;
    int ys;
    int xe;
    int ye;
    int reach;
    int span;
    int ticks;
    kind = $urandom_range(0, 99);
    xs = $urandom_range(0, COORD_MAX);
    ys = $urandom_range(0, COORD_MAX);
    if (kind < 8) begin
      send_request(1'($urandom_range(0, 1)), COORD_W'(xs), COORD_W'(ys),
                   COORD_W'($urandom_range(0, COORD_MAX)),
                   COORD_W'($urandom_range(0, COORD_MAX)));
      return;
    end
    if (kind < 16) begin
      // A long line over the whole range, dropped after a few points.
      xe = $urandom_range(0, COORD_MAX);
      ye = $urandom_range(0, COORD_MAX);
      run_line(xs, ys, xe, ye, $urandom_range(1, 30));
      return;
    end
    if (kind < 19) begin
      reach = 0;
    end else if (kind < 23) begin
      reach = 300;
    end else begin
      reach = 24;
    end
    xe = xs + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, reach);
    ye = ys + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, reach);
    xe = (xe < 0) ? 0 : (xe > COORD_MAX) ? COORD_MAX : xe;
    ye = (ye < 0) ? 0 : (ye > COORD_MAX) ? COORD_MAX : ye;
    span = (xe > xs ? xe - xs : xs - xe);
    if ((ye > ys ? ye - ys : ys - ye) > span) begin
      span = (ye > ys ? ye - ys : ys - ye);
    end
    ticks = span + 1;
    if (kind >= 88) begin
      ticks = ticks + $urandom_range(1, 3);
    end else if (kind >= 80) begin
      ticks = $urandom_range(0, span);
    end
    run_line(xs, ys, xe, ye, ticks);
  endtask

  task automatic test_random_lines();
    int phase;
    int phase_end;
    phase = 0;
    while (counted_requests < TARGET_REQUESTS) begin
      case (phase % 6)
        0: write_spacing(1);
        1: write_spacing($urandom_range(2, 8));
        2: write_spacing(255);
        3: write_spacing($urandom_range(1, 255));
        4: write_spacing(2);
        default: write_spacing($urandom_range(9, 40));
      endcase
      rx_pattern = rx_pattern_t'(phase % 4);
      tx_gaps = (phase % 3 != 0);
      phase_end = counted_requests + 110;
      while (counted_requests < phase_end && counted_requests < TARGET_REQUESTS) begin
        random_sequence();
      end
      phase++;
    end
    drain_block();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tuser = dls_pkg::OP_START;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_lines();
    test_dash_spacing();
    test_backpressure();
    test_random_lines();

    $display("Covered %0d lines and %0d requests, checked %0d points (%0d plotted, %0d line ends).",
             lines_started, counted_requests, points_checked, points_plotted, lines_finished);
    $display("Made %0d spacing writes, saw %0d input stall cycles and %0d mismatches.",
             spacing_writes, input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop: this is several times longer than the slowest correct run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
